@@ hdl/sbph_pkg.sv @@
// Shared types and constants of the spectrum bar peak hold renderer.
// No dependencies; imported by every module in hdl/.
package sbph_pkg;

	localparam int COLUMNS = 32;
	localparam int ROWS    = 8;

	localparam int COL_W   = 5;
	localparam int COL_AW  = $clog2(COLUMNS);
	localparam int LVL_W   = 4;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 8;
	localparam int COLOR_W = 24;
	localparam int CH_W    = 8;
	localparam int CFG_W   = 2 * COLOR_W;
	localparam int CFG_AW  = 3;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	localparam logic [ROW_W-1:0]   BOTTOM_ROW       = ROW_W'(ROWS - 1);
	localparam logic [LVL_W-1:0]   LEVEL_MAX        = LVL_W'(ROWS);
	localparam logic [CNT_W-1:0]   FALL_TICKS_RESET = CNT_W'(15);
	localparam logic [COLOR_W-1:0] PEAK_COLOR_RESET = 24'h28280A;

	localparam logic [CFG_AW-1:0] CFG_FALL_TICKS  = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] CFG_PEAK_COLOR  = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] CFG_BAR_ROWS_01 = CFG_AW'(2);
	localparam logic [CFG_AW-1:0] CFG_BAR_ROWS_23 = CFG_AW'(3);
	localparam logic [CFG_AW-1:0] CFG_BAR_ROWS_45 = CFG_AW'(4);
	localparam logic [CFG_AW-1:0] CFG_BAR_ROWS_67 = CFG_AW'(5);

	typedef logic [CFG_W-1:0] color_pair_t;
	typedef color_pair_t [ROWS/2-1:0] bar_colors_t;

	typedef struct packed {
		logic [COLOR_W-1:0] peak_color;
		bar_colors_t        bar_colors;
	} disp_cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LVL_W-1:0] level;
		logic [ROW_W-1:0] peak;
	} column_item_t;

endpackage

@@ hdl/sbph_peak.sv @@
// Per-column peak dot state: peak row and fall counter with read-modify-write.
// Depends on sbph_pkg.
module sbph_peak (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [sbph_pkg::COL_W-1:0]  column,
	input  logic [sbph_pkg::LVL_W-1:0]  level,
	input  logic [sbph_pkg::CNT_W-1:0]  fall_ticks,
	output logic [sbph_pkg::ROW_W-1:0]  peak
);
	import sbph_pkg::*;

	logic [ROW_W-1:0] peak_q [COLUMNS];
	logic [CNT_W-1:0] cnt_q  [COLUMNS];

	logic [COL_AW-1:0] idx;
	logic [ROW_W-1:0]  target;
	logic [ROW_W-1:0]  cur_peak;
	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  inc;
	logic              rise;
	logic              expire;
	logic [CNT_W-1:0]  new_cnt;

	assign idx      = column[COL_AW-1:0];
	assign cur_peak = peak_q[idx];
	assign cur_cnt  = cnt_q[idx];
	assign target   = (level >= LVL_W'(BOTTOM_ROW)) ? '0 : BOTTOM_ROW - level[ROW_W-1:0];
	assign inc      = cur_cnt + CNT_W'(1);
	assign rise     = (target <= cur_peak);
	assign expire   = (inc == fall_ticks);

	always_comb begin
		if (rise) begin
			peak    = target;
			new_cnt = '0;
		end else if (expire) begin
			peak    = (cur_peak != BOTTOM_ROW) ? cur_peak + ROW_W'(1) : cur_peak;
			new_cnt = '0;
		end else begin
			peak    = cur_peak;
			new_cnt = inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COLUMNS; c++) begin
				peak_q[c] <= BOTTOM_ROW;
				cnt_q[c]  <= '0;
			end
		end else if (upd) begin
			peak_q[idx] <= peak;
			cnt_q[idx]  <= new_cnt;
		end
	end

endmodule

@@ hdl/sbph_pixel.sv @@
// Column expander: holds one column item and emits its pixel writes bottom to top
// through a registered output stage. Depends on sbph_pkg.
module sbph_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sbph_pkg::column_item_t            item,
	input  sbph_pkg::disp_cfg_t               cfg,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sbph_pkg::OUT_DATA_W-1:0]   m_tdata,   // pixel_index, red, green, blue
	output logic                              m_tlast    // last_pixel
);
	import sbph_pkg::*;

	logic             v_s2;
	column_item_t     item_s2;
	logic [ROW_W-1:0] j_q;

	logic               v_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic [COLOR_W-1:0] color_s3;
	logic               last_s3;

	logic               adv3;
	logic               emit;
	logic               top;
	logic [ROW_W-1:0]   row;
	logic [ROW_W-1:0]   sub;
	logic [IDX_W-1:0]   idx;
	logic [COLOR_W-1:0] color;
	color_pair_t        pair;

	assign adv3     = !v_s3 || m_tready;
	assign emit     = v_s2 && adv3;
	assign top      = (j_q == BOTTOM_ROW);
	assign in_ready = !v_s2 || (emit && top);

	assign row  = BOTTOM_ROW - j_q;
	assign sub  = item_s2.column[0] ? j_q : row;
	assign idx  = IDX_W'({item_s2.column, sub});
	assign pair = cfg.bar_colors[row[ROW_W-1:1]];

	always_comb begin
		if (row == item_s2.peak)
			color = cfg.peak_color;
		else if ({1'b0, j_q} < item_s2.level)
			color = row[0] ? pair[CFG_W-1:COLOR_W] : pair[COLOR_W-1:0];
		else
			color = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			j_q  <= '0;
			v_s3 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s2 <= 1'b1;
				j_q  <= '0;
			end else begin
				if (emit && top)
					v_s2 <= 1'b0;
				if (emit)
					j_q <= j_q + ROW_W'(1);
			end
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s2 <= item;
		if (emit) begin
			idx_s3   <= idx;
			color_s3 <= color;
			last_s3  <= top;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {color_s3[CH_W-1:0], color_s3[2*CH_W-1:CH_W],
	                   color_s3[3*CH_W-1:2*CH_W], idx_s3};
	assign m_tlast  = last_s3;

	a_last_on_top: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (last_s3 == ($past(j_q) == BOTTOM_ROW)))
		else $error("last pixel flag does not match the top row");

	a_take_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && in_ready) |-> (emit && top))
		else $error("column taken before its last pixel was emitted");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (v_s2 && j_q == '0))
		else $error("new column does not start at the bottom row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv3) |=> (j_q == $past(j_q)))
		else $error("row counter advanced while the output stalled");

endmodule

@@ hdl/spectrum_bar_peak_hold_renderer.sv @@
// Top level of the spectrum bar peak hold renderer: stream ports, configuration
// registers, input stage. Depends on sbph_pkg, sbph_peak and sbph_pixel.
//
// Each accepted column request yields eight pixel writes, bottom row first, the
// top row marked by tlast. The output register passes one pixel per cycle while
// m_tready is high; each request passes the input register, the expander and
// the output register, and the next column is taken while the previous one
// is still being written, so back-to-back columns stream without gaps. The peak
// row and fall counter of a column are updated as the column enters the expander,
// so repeated requests for the same column need no spacing. Configuration is to
// be written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module spectrum_bar_peak_hold_renderer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sbph_pkg::IN_DATA_W-1:0]    s_tdata,   // column, bar_level, zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sbph_pkg::OUT_DATA_W-1:0]   m_tdata,   // pixel_index, red, green, blue
	output logic                              m_tlast,   // last_pixel
	input  logic                              cfg_we,
	input  logic [sbph_pkg::CFG_AW-1:0]       cfg_index,
	input  logic [sbph_pkg::CFG_W-1:0]        cfg_data
);
	import sbph_pkg::*;

	logic [CNT_W-1:0]   fall_ticks_q;
	logic [COLOR_W-1:0] peak_color_q;
	bar_colors_t        bar_colors_q;
	disp_cfg_t          disp_cfg;

	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	logic [LVL_W-1:0] lvl_s1;

	logic             col_ok;
	logic             pix_ready;
	logic             upd;
	logic [LVL_W-1:0] lvl_in;
	logic [ROW_W-1:0] peak;
	column_item_t     item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_ticks_q <= FALL_TICKS_RESET;
			peak_color_q <= PEAK_COLOR_RESET;
			bar_colors_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FALL_TICKS:  fall_ticks_q    <= cfg_data[CNT_W-1:0];
				CFG_PEAK_COLOR:  peak_color_q    <= cfg_data[COLOR_W-1:0];
				CFG_BAR_ROWS_01: bar_colors_q[0] <= cfg_data;
				CFG_BAR_ROWS_23: bar_colors_q[1] <= cfg_data;
				CFG_BAR_ROWS_45: bar_colors_q[2] <= cfg_data;
				CFG_BAR_ROWS_67: bar_colors_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign disp_cfg.peak_color = peak_color_q;
	assign disp_cfg.bar_colors = bar_colors_q;

	assign lvl_in   = (s_tdata[COL_W+LVL_W-1:COL_W] > LEVEL_MAX) ? LEVEL_MAX :
	                  s_tdata[COL_W+LVL_W-1:COL_W];
	assign col_ok   = ({1'b0, col_s1} < (COL_W+1)'(COLUMNS));
	assign upd      = v_s1 && col_ok && pix_ready;
	assign s_tready = !v_s1 || pix_ready || !col_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			col_s1 <= s_tdata[COL_W-1:0];
			lvl_s1 <= lvl_in;
		end
	end

	sbph_peak u_peak (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.column     (col_s1),
		.level      (lvl_s1),
		.fall_ticks (fall_ticks_q),
		.peak       (peak)
	);

	assign item.column = col_s1;
	assign item.level  = lvl_s1;
	assign item.peak   = peak;

	sbph_pixel u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1 && col_ok),
		.in_ready (pix_ready),
		.item     (item),
		.cfg      (disp_cfg),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
